>>> rtl/core/fec_pkg.sv
// Shared types, widths, reset values and the generator's start-up table
// for the fire-field cell updater. No dependencies.
package fec_pkg;

    // Item field widths
    localparam int ROW_W  = 7;
    localparam int COL_W  = 7;
    localparam int CELL_W = 8;
    localparam int SUM_W  = CELL_W + 2;

    // Default field size
    localparam int DEF_CELL_COLS = 120;
    localparam int DEF_CELL_ROWS = 80;

    // Lagged generator
    localparam int WORD_W      = 16;
    localparam int TABLE_DEPTH = 64;
    localparam int TBL_AW      = $clog2(TABLE_DEPTH);

    localparam logic [TBL_AW-1:0] LAG_A_RESET = TBL_AW'(29);
    localparam logic [TBL_AW-1:0] LAG_B_RESET = TBL_AW'(63);

    // Configuration registers
    localparam logic [CELL_W-1:0] SEED_BIAS_RESET = 8'd10;
    localparam logic [CELL_W-1:0] SEED_MASK_RESET = 8'd191;

    localparam logic REG_SEED_BIAS = 1'b0;
    localparam logic REG_SEED_MASK = 1'b1;

    // Item opcodes
    localparam logic OP_STEP = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Generator table contents after reset; last word repaired to zero
    localparam logic [WORD_W-1:0] RNG_INIT [TABLE_DEPTH] = '{
        16'd25662, 16'd56977, 16'd36314, 16'd46707, 16'd56747, 16'd47936, 16'd28467, 16'd50155,
        16'd54470, 16'd9126,  16'd19191, 16'd26274, 16'd27205, 16'd13469, 16'd6769,  16'd48786,
        16'd43195, 16'd17969, 16'd58549, 16'd13097, 16'd9962,  16'd26613, 16'd60724, 16'd25428,
        16'd44416, 16'd43884, 16'd31777, 16'd40699, 16'd4280,  16'd32767, 16'd31882, 16'd41912,
        16'd19050, 16'd42386, 16'd38267, 16'd39411, 16'd11739, 16'd36780, 16'd10921, 16'd43911,
        16'd7473,  16'd38901, 16'd28614, 16'd62047, 16'd25094, 16'd22064, 16'd16149, 16'd14666,
        16'd46209, 16'd34643, 16'd30017, 16'd25842, 16'd64242, 16'd3527,  16'd34102, 16'd35358,
        16'd2277,  16'd3678,  16'd16479, 16'd3431,  16'd36135, 16'd63741, 16'd11311, 16'd0
    };

    // Field memory access request
    typedef struct packed {
        logic rd;
        logic wr;
    } fld_cmd_t;

endpackage

>>> rtl/core/fec_field.sv
// Fire field store: single-port synchronous cell memory with a clearing
// sweep after reset. Depends on fec_pkg.
module fec_field #(
    parameter int DEPTH = fec_pkg::DEF_CELL_ROWS * fec_pkg::DEF_CELL_COLS,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  fec_pkg::fld_cmd_t         cmd,
    input  logic [AW-1:0]             addr,
    input  logic [fec_pkg::CELL_W-1:0] wdata,
    output logic [fec_pkg::CELL_W-1:0] rdata,
    output logic                      clearing
);
    import fec_pkg::*;

    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    logic [CELL_W-1:0] cells_mem [DEPTH];
    logic [CELL_W-1:0] rdata_reg;

    logic          clear_reg;
    logic          clear_next;
    logic [AW-1:0] clr_addr_reg;
    logic [AW-1:0] clr_addr_next;

    logic              we;
    logic [AW-1:0]     waddr;
    logic [CELL_W-1:0] wd;

    // Advance the clearing sweep, one cell a cycle
    always_comb
    begin
        clear_next    = clear_reg;
        clr_addr_next = clr_addr_reg;
        if (clear_reg)
        begin
            if (clr_addr_reg == LAST_ADDR)
            begin
                clear_next = 1'b0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg    <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clear_reg    <= clear_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // Steer the single write port
    always_comb
    begin
        we    = clear_reg | cmd.wr;
        waddr = clear_reg ? clr_addr_reg : addr;
        wd    = clear_reg ? '0 : wdata;
    end

    // Memory array and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            cells_mem[waddr] <= wd;
        end
        else if (cmd.rd)
        begin
            rdata_reg <= cells_mem[addr];
        end
    end

    assign rdata    = rdata_reg;
    assign clearing = clear_reg;

endmodule

>>> rtl/core/fec_rng.sv
// Additive lagged random word generator over a 64-word table memory.
// Entries not yet rewritten read from the start-up table. Depends on fec_pkg.
module fec_rng (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req,
    output logic [fec_pkg::WORD_W-1:0] word
);
    import fec_pkg::*;

    logic [WORD_W-1:0] tbl_mem [TABLE_DEPTH];

    logic [TBL_AW-1:0]      idx_a_reg;
    logic [TBL_AW-1:0]      idx_a_next;
    logic [TBL_AW-1:0]      idx_b_reg;
    logic [TBL_AW-1:0]      idx_b_next;
    logic [TABLE_DEPTH-1:0] vld_reg;
    logic [TABLE_DEPTH-1:0] vld_next;
    logic                   calc_reg;
    logic                   calc_next;

    logic [WORD_W-1:0] a_raw_reg;
    logic [WORD_W-1:0] b_raw_reg;
    logic [WORD_W-1:0] a_init_reg;
    logic [WORD_W-1:0] b_init_reg;
    logic              a_vld_reg;
    logic              b_vld_reg;
    logic [WORD_W-1:0] word_reg;

    logic [WORD_W-1:0] a_word;
    logic [WORD_W-1:0] b_word;
    logic [WORD_W-1:0] sum;

    // Pick stored or start-up words and add them
    always_comb
    begin
        a_word = a_vld_reg ? a_raw_reg : a_init_reg;
        b_word = b_vld_reg ? b_raw_reg : b_init_reg;
        sum    = a_word + b_word;
    end

    // Advance indices and mark the rewritten entry
    always_comb
    begin
        idx_a_next = idx_a_reg;
        idx_b_next = idx_b_reg;
        vld_next   = vld_reg;
        calc_next  = req;
        if (calc_reg)
        begin
            idx_a_next          = idx_a_reg + 1'b1;
            idx_b_next          = idx_b_reg + 1'b1;
            vld_next[idx_b_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_a_reg <= LAG_A_RESET;
            idx_b_reg <= LAG_B_RESET;
            vld_reg   <= '0;
            calc_reg  <= 1'b0;
        end
        else
        begin
            idx_a_reg <= idx_a_next;
            idx_b_reg <= idx_b_next;
            vld_reg   <= vld_next;
            calc_reg  <= calc_next;
        end
    end

    // Table memory: two reads on request, write back the new word
    always_ff @(posedge clk)
    begin
        if (calc_reg)
        begin
            tbl_mem[idx_b_reg] <= sum;
        end
        if (req)
        begin
            a_raw_reg <= tbl_mem[idx_a_reg];
            b_raw_reg <= tbl_mem[idx_b_reg];
        end
    end

    // Hold start-up words, valid flags and the result word
    always_ff @(posedge clk)
    begin
        if (req)
        begin
            a_init_reg <= RNG_INIT[idx_a_reg];
            b_init_reg <= RNG_INIT[idx_b_reg];
            a_vld_reg  <= vld_reg[idx_a_reg];
            b_vld_reg  <= vld_reg[idx_b_reg];
        end
        if (calc_reg)
        begin
            word_reg <= sum;
        end
    end

    assign word = word_reg;

endmodule

>>> rtl/core/fire_effect_cell_updater_top.sv
// Fire-field cell updater: top level with the step sequencer and result register.
// Depends on fec_pkg, fec_field and fec_rng.
//
// Usage:
//   Input channel (in_valid/in_ready): opcode, read_row, read_col. A step item
//   rewrites the next cell of the column-major scan; a read item returns one
//   cell. Every item gives exactly one result item on the output channel
//   (out_valid/out_ready).
//   Timing: all field traffic goes through the single port of the field
//   memory. A step item passes through four neighbour reads (the last two are
//   skipped in the last column), an accumulate state, one write and the
//   result hand-off, with a further write of the seed cell when it ends a
//   column. A read item passes through a cell read, a data capture and the
//   hand-off. The result enters the output register as in_ready rises again.
//   Reset: the field memory is swept to zero, one cell a cycle, over all
//   CELL_ROWS*CELL_COLS cells (9600 at the default size); in_ready stays low
//   until the sweep ends. Configuration writes are taken at any time.
//   Stalls: a result waits in the output register while out_ready is low; the
//   next item is still accepted and worked on, and its result waits until the
//   register is free.
//   Configuration: cfg_we with cfg_index selects seed_bias (0) or seed_mask (1).
module fire_effect_cell_updater_top #(
    parameter int CELL_COLS = fec_pkg::DEF_CELL_COLS,
    parameter int CELL_ROWS = fec_pkg::DEF_CELL_ROWS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       opcode,
    input  logic [fec_pkg::ROW_W-1:0]  read_row,
    input  logic [fec_pkg::COL_W-1:0]  read_col,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [fec_pkg::ROW_W-1:0]  cell_row,
    output logic [fec_pkg::COL_W-1:0]  cell_col,
    output logic [fec_pkg::CELL_W-1:0] cell_value,
    output logic                       seed_written,
    output logic [fec_pkg::CELL_W-1:0] seed_value,
    output logic                       frame_done,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [fec_pkg::CELL_W-1:0] cfg_wdata
);
    import fec_pkg::*;

    localparam int DEPTH = CELL_ROWS * CELL_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(CELL_ROWS);
    localparam int CW    = $clog2(CELL_COLS);

    localparam logic [AW-1:0] COLS_A    = AW'(CELL_COLS);
    localparam logic [AW-1:0] SEED_BASE = AW'((CELL_ROWS - 2) * CELL_COLS);
    localparam logic [RW-1:0] SEED_ROW  = RW'(CELL_ROWS - 2);
    localparam logic [CW-1:0] LAST_COL  = CW'(CELL_COLS - 1);
    localparam logic [RW-1:0] ROW_ONE   = RW'(1);
    localparam logic [CW-1:0] COL_ONE   = CW'(1);

    typedef enum logic [10:0] {
        S_IDLE      = 11'b000_0000_0001,
        S_RD_A      = 11'b000_0000_0010,
        S_RD_B      = 11'b000_0000_0100,
        S_RD_C      = 11'b000_0000_1000,
        S_RD_D      = 11'b000_0001_0000,
        S_ACC       = 11'b000_0010_0000,
        S_WR_V      = 11'b000_0100_0000,
        S_WR_S      = 11'b000_1000_0000,
        S_RD_CELL   = 11'b001_0000_0000,
        S_CELL_DATA = 11'b010_0000_0000,
        S_DONE      = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Scan position and configuration
    logic [RW-1:0]     scan_row_reg;
    logic [RW-1:0]     scan_row_next;
    logic [CW-1:0]     scan_col_reg;
    logic [CW-1:0]     scan_col_next;
    logic [CELL_W-1:0] bias_reg;
    logic [CELL_W-1:0] bias_next;
    logic [CELL_W-1:0] mask_reg;
    logic [CELL_W-1:0] mask_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    // Working item
    logic [AW-1:0]     base_reg;
    logic [AW-1:0]     base_next;
    logic [CW-1:0]     col_reg;
    logic [CW-1:0]     col_next;
    logic [ROW_W-1:0]  res_row_reg;
    logic [ROW_W-1:0]  res_row_next;
    logic [COL_W-1:0]  res_col_reg;
    logic [COL_W-1:0]  res_col_next;
    logic              edge_reg;
    logic              edge_next;
    logic              seed_reg;
    logic              seed_next;
    logic              done_reg;
    logic              done_next;
    logic              rd_ok_reg;
    logic              rd_ok_next;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [CELL_W-1:0] val_reg;
    logic [CELL_W-1:0] val_next;
    logic [CELL_W-1:0] sv_reg;
    logic [CELL_W-1:0] sv_next;

    // Output register payload
    logic [ROW_W-1:0]  o_row_reg;
    logic [COL_W-1:0]  o_col_reg;
    logic [CELL_W-1:0] o_val_reg;
    logic              o_seed_reg;
    logic [CELL_W-1:0] o_sv_reg;
    logic              o_done_reg;

    // Field memory and generator connections
    fld_cmd_t          fld_cmd;
    logic [AW-1:0]     fld_addr;
    logic [CELL_W-1:0] fld_wdata;
    logic [CELL_W-1:0] fld_rdata;
    logic              clearing;
    logic              rng_req;
    logic [WORD_W-1:0] rng_word;

    logic              accept;
    logic              load;
    logic [CELL_W-1:0] avg;
    logic [CELL_W-1:0] new_val;
    logic [CELL_W-1:0] new_seed;

    fec_field #(
        .DEPTH (DEPTH)
    ) u_field (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (fld_cmd),
        .addr     (fld_addr),
        .wdata    (fld_wdata),
        .rdata    (fld_rdata),
        .clearing (clearing)
    );

    fec_rng u_rng (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rng_req),
        .word  (rng_word)
    );

    assign in_ready = (state_reg == S_IDLE) && !clearing;
    assign accept   = in_valid && in_ready;
    assign load     = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    // Cell and seed values
    always_comb
    begin
        avg      = sum_reg[SUM_W-1:2];
        new_val  = (avg != '0) ? avg - 1'b1 : '0;
        new_seed = (rng_word[CELL_W-1:0] + bias_reg) & mask_reg;
    end

    // Sequencer: issue neighbour reads, accumulate, write back; or read one cell
    always_comb
    begin
        state_next    = state_reg;
        scan_row_next = scan_row_reg;
        scan_col_next = scan_col_reg;
        base_next     = base_reg;
        col_next      = col_reg;
        res_row_next  = res_row_reg;
        res_col_next  = res_col_reg;
        edge_next     = edge_reg;
        seed_next     = seed_reg;
        done_next     = done_reg;
        rd_ok_next    = rd_ok_reg;
        sum_next      = sum_reg;
        val_next      = val_reg;
        sv_next       = sv_reg;
        fld_cmd       = '0;
        fld_addr      = base_reg;
        fld_wdata     = '0;
        rng_req       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    sum_next = '0;
                    sv_next  = '0;
                    if (opcode == OP_READ)
                    begin
                        res_row_next = read_row;
                        res_col_next = read_col;
                        rd_ok_next   = (int'(read_row) < CELL_ROWS)
                                    && (int'(read_col) < CELL_COLS);
                        base_next    = AW'(read_row) * COLS_A + AW'(read_col);
                        seed_next    = 1'b0;
                        done_next    = 1'b0;
                        state_next   = S_RD_CELL;
                    end
                    else
                    begin
                        base_next    = AW'(scan_row_reg) * COLS_A + AW'(scan_col_reg);
                        col_next     = scan_col_reg;
                        res_row_next = ROW_W'(scan_row_reg - ROW_ONE);
                        res_col_next = COL_W'(scan_col_reg);
                        edge_next    = (scan_col_reg == LAST_COL);
                        seed_next    = (scan_row_reg >= SEED_ROW);
                        done_next    = (scan_row_reg >= SEED_ROW)
                                    && (scan_col_reg == LAST_COL);
                        rng_req      = (scan_row_reg >= SEED_ROW);
                        // Advance the scan position
                        if (scan_row_reg >= SEED_ROW)
                        begin
                            scan_row_next = ROW_ONE;
                            scan_col_next = (scan_col_reg == LAST_COL) ? COL_ONE
                                          : scan_col_reg + 1'b1;
                        end
                        else
                        begin
                            scan_row_next = scan_row_reg + 1'b1;
                        end
                        state_next = S_RD_A;
                    end
                end
            end
            S_RD_A:
            begin
                fld_cmd.rd = 1'b1;
                fld_addr   = base_reg - 1'b1;
                state_next = S_RD_B;
            end
            S_RD_B:
            begin
                fld_cmd.rd = 1'b1;
                fld_addr   = base_reg;
                sum_next   = sum_reg + SUM_W'(fld_rdata);
                state_next = S_RD_C;
            end
            S_RD_C:
            begin
                fld_cmd.rd = !edge_reg;
                fld_addr   = base_reg + 1'b1;
                sum_next   = sum_reg + SUM_W'(fld_rdata);
                state_next = S_RD_D;
            end
            S_RD_D:
            begin
                fld_cmd.rd = !edge_reg;
                fld_addr   = base_reg + COLS_A + 1'b1;
                if (!edge_reg)
                begin
                    sum_next = sum_reg + SUM_W'(fld_rdata);
                end
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (!edge_reg)
                begin
                    sum_next = sum_reg + SUM_W'(fld_rdata);
                end
                state_next = S_WR_V;
            end
            S_WR_V:
            begin
                fld_cmd.wr = 1'b1;
                fld_addr   = base_reg - COLS_A;
                fld_wdata  = new_val;
                val_next   = new_val;
                state_next = seed_reg ? S_WR_S : S_DONE;
            end
            S_WR_S:
            begin
                fld_cmd.wr = 1'b1;
                fld_addr   = SEED_BASE + AW'(col_reg);
                fld_wdata  = new_seed;
                sv_next    = new_seed;
                state_next = S_DONE;
            end
            S_RD_CELL:
            begin
                fld_cmd.rd = rd_ok_reg;
                state_next = S_CELL_DATA;
            end
            S_CELL_DATA:
            begin
                val_next   = rd_ok_reg ? fld_rdata : '0;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Configuration writes and output valid
    always_comb
    begin
        bias_next = bias_reg;
        mask_next = mask_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SEED_BIAS: bias_next = cfg_wdata;
                REG_SEED_MASK: mask_next = cfg_wdata;
            endcase
        end

        out_valid_next = out_valid_reg && !out_ready;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            scan_row_reg  <= ROW_ONE;
            scan_col_reg  <= COL_ONE;
            bias_reg      <= SEED_BIAS_RESET;
            mask_reg      <= SEED_MASK_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_row_reg  <= scan_row_next;
            scan_col_reg  <= scan_col_next;
            bias_reg      <= bias_next;
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the working item
    always_ff @(posedge clk)
    begin
        base_reg    <= base_next;
        col_reg     <= col_next;
        res_row_reg <= res_row_next;
        res_col_reg <= res_col_next;
        edge_reg    <= edge_next;
        seed_reg    <= seed_next;
        done_reg    <= done_next;
        rd_ok_reg   <= rd_ok_next;
        sum_reg     <= sum_next;
        val_reg     <= val_next;
        sv_reg      <= sv_next;
    end

    // Load the result item into the output register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            o_row_reg  <= res_row_reg;
            o_col_reg  <= res_col_reg;
            o_val_reg  <= val_reg;
            o_seed_reg <= seed_reg;
            o_sv_reg   <= sv_reg;
            o_done_reg <= done_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign cell_row     = o_row_reg;
    assign cell_col     = o_col_reg;
    assign cell_value   = o_val_reg;
    assign seed_written = o_seed_reg;
    assign seed_value   = o_sv_reg;
    assign frame_done   = o_done_reg;

endmodule
